/* rtl/core/fslf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslf_pkg
// Shared constants, codes and types of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fslf_pkg;

  localparam int POOL_SLOTS   = 64;
  localparam int PAYLOAD_BITS = 32;

  // fixed field widths of the item ports
  localparam int MODE_W       = 2;
  localparam int INDEX_W      = 7;
  localparam int PAYLOAD_IO_W = 32;
  localparam int GRANT_W      = 6;

  localparam int SLOT_W = $clog2(POOL_SLOTS);      // slot address
  localparam int LINK_W = $clog2(POOL_SLOTS + 1);  // link incl. null value
  localparam int META_W = LINK_W + 1;              // {used, link}
  localparam int PAY_W  = (PAYLOAD_BITS < PAYLOAD_IO_W) ? PAYLOAD_BITS : PAYLOAD_IO_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_link;
    logic              wr_used;
    logic              clear;
  } link_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic              used;
  } link_rsp_t;

endpackage

/* rtl/core/fslf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fslf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/fslf_link_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslf_link_store
// Link/used memory with per-slot valid bits; an invalid slot reads as its
// reset value (link = slot + 1, not used). Clear drops all valid bits.
// ----------------------------------------------------------------------------
module fslf_link_store
  import fslf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  link_req_t req,
  output link_rsp_t rsp
);

  logic [POOL_SLOTS-1:0] vld;
  logic                  rd_vld;
  logic [SLOT_W-1:0]     rd_addr_q;
  logic [META_W-1:0]     wr_data;
  logic [META_W-1:0]     rd_data;

  assign wr_data = {req.wr_used, req.wr_link};

  fslf_ram #(
    .WIDTH (META_W),
    .DEPTH (POOL_SLOTS)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.clear) begin
        vld <= '0;
      end else if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_addr_q <= req.rd_addr;
    end
  end

  assign rsp.link = rd_vld ? rd_data[LINK_W-1:0] : LINK_W'(rd_addr_q) + LINK_W'(1);
  assign rsp.used = rd_vld & rd_data[LINK_W];

endmodule

/* rtl/core/fixed_slot_free_list_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Pool of fixed slots with a free list: allocate, checked free, read, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries mode, slot_index and
//   payload_in. Response channel (rsp_valid / rsp_stall) carries ok,
//   granted_slot, payload_out, slot_used and pool_full; one response per
//   request, in order.
//   At the accept edge a request issues the reads of the link/used memory
//   and the payload memory; in the execute state the registered read data
//   is consumed, written back and loaded into the response register once
//   the output register is free. A request is accepted only in the idle
//   state, so the next one waits while the previous one executes, as the
//   registered read of the link memory comes ahead of its write-back.
//   A new request is accepted while a response still waits in the output
//   register; if the receiver stalls, the second request parks in the
//   execute state (read data held) until the output register frees up.
//   Reset: free list starts at slot 0 with slot i linked to i+1, nothing used.
//   Link reset values come from per-slot valid bits, so reset and clear
//   only drop those bits; payload contents survive clear.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator
  import fslf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic [MODE_W-1:0]       mode,
  input  logic [INDEX_W-1:0]      slot_index,
  input  logic [PAYLOAD_IO_W-1:0] payload_in,
  // response channel
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic                    ok,
  output logic [GRANT_W-1:0]      granted_slot,
  output logic [PAYLOAD_IO_W-1:0] payload_out,
  output logic                    slot_used,
  output logic                    pool_full
);

  state_t state, state_next;

  logic [LINK_W-1:0] head, head_next;

  // captured request
  mode_t             mode_q;
  logic [INDEX_W-1:0] idx_q;
  logic [PAY_W-1:0]  pay_q;

  logic accept;
  logic done;       // execute state may retire into the output register

  link_req_t link_req;
  link_rsp_t link_rsp;

  logic              pay_wr_en;
  logic              pay_rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [PAY_W-1:0]  pay_rd;

  // response staged before the output register
  logic                    res_ok;
  logic [GRANT_W-1:0]      res_grant;
  logic [PAYLOAD_IO_W-1:0] res_pay;
  logic                    res_used;

  logic              have_free;
  logic              in_range;
  logic [SLOT_W-1:0] read_slot;

  assign have_free = head < LINK_W'(POOL_SLOTS);
  assign in_range  = 32'(idx_q) < POOL_SLOTS;
  assign read_slot = SLOT_W'(idx_q % POOL_SLOTS);

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  fslf_link_store u_link_store (
    .clk (clk),
    .rst (rst),
    .req (link_req),
    .rsp (link_rsp)
  );

  fslf_ram #(
    .WIDTH (PAY_W),
    .DEPTH (POOL_SLOTS)
  ) u_payload_ram (
    .clk     (clk),
    .wr_en   (pay_wr_en),
    .wr_addr (SLOT_W'(head)),
    .wr_data (pay_q),
    .rd_en   (pay_rd_en),
    .rd_addr (rd_addr),
    .rd_data (pay_rd)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  assign done = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (read issue, write-back, response)
  // --------------------------------------------------------------------------
  always_comb begin
    req_stall = 1'b1;
    accept    = 1'b0;
    link_req  = '0;
    pay_rd_en = 1'b0;
    pay_wr_en = 1'b0;
    head_next = head;
    res_ok    = 1'b0;
    res_grant = '0;
    res_pay   = '0;
    res_used  = 1'b0;

    // read address by mode of the incoming request
    case (mode_t'(mode))
      MODE_ALLOC: rd_addr = SLOT_W'(head);
      MODE_FREE:  rd_addr = SLOT_W'(slot_index);
      MODE_READ:  rd_addr = SLOT_W'(slot_index % POOL_SLOTS);
      default:    rd_addr = '0;
    endcase

    case (state)
      ST_IDLE: begin
        req_stall        = 1'b0;
        accept           = req_valid;
        link_req.rd_en   = req_valid;
        link_req.rd_addr = rd_addr;
        pay_rd_en        = req_valid;
      end
      ST_EXEC: begin
        case (mode_q)
          MODE_ALLOC: begin
            if (have_free) begin
              // pop head: link field is kept, slot marked used
              link_req.wr_en   = done;
              link_req.wr_addr = SLOT_W'(head);
              link_req.wr_link = link_rsp.link;
              link_req.wr_used = 1'b1;
              pay_wr_en        = done;
              head_next        = (link_rsp.link > LINK_W'(POOL_SLOTS)) ?
                                 LINK_W'(POOL_SLOTS) : link_rsp.link;
              res_ok           = 1'b1;
              res_grant        = GRANT_W'(head);
              res_pay          = PAYLOAD_IO_W'(pay_q);
              res_used         = 1'b1;
            end
          end
          MODE_FREE: begin
            res_grant = GRANT_W'(idx_q);
            if (in_range && link_rsp.used) begin
              // push slot onto the list
              link_req.wr_en   = done;
              link_req.wr_addr = SLOT_W'(idx_q);
              link_req.wr_link = head;
              link_req.wr_used = 1'b0;
              head_next        = LINK_W'(idx_q);
              res_ok           = 1'b1;
            end
          end
          MODE_READ: begin
            res_ok    = 1'b1;
            res_grant = GRANT_W'(read_slot);
            res_pay   = PAYLOAD_IO_W'(pay_rd);
            res_used  = link_rsp.used;
          end
          MODE_CLEAR: begin
            link_req.clear = done;
            head_next      = '0;
            res_ok         = 1'b1;
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC && done) begin
        head      <= head_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode_t'(mode);
      idx_q  <= slot_index;
      pay_q  <= payload_in[PAY_W-1:0];
    end
    if (state == ST_EXEC && done) begin
      ok           <= res_ok;
      granted_slot <= res_grant;
      payload_out  <= res_pay;
      slot_used    <= res_used;
      pool_full    <= head_next >= LINK_W'(POOL_SLOTS);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LINK_W'(POOL_SLOTS))
    else $error("free head beyond null link");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted request did not enter execute");

  a_head_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && mode_q == MODE_ALLOC && have_free) |-> !link_rsp.used)
    else $error("free list head slot is marked used");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && mode_q == MODE_CLEAR && done) |=>
      (rsp_valid && ok && !pool_full && head == '0))
    else $error("clear did not restore the free list");

endmodule
